[hw/rtl/bfa_pkg.sv]
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared constants, codes and types for the bitmap frame allocator.
// ----------------------------------------------------------------------------
package bfa_pkg;

  localparam int MAX_FRAMES_DEF  = 65536;
  localparam int FRAME_BYTES_DEF = 4096;
  localparam int LOW_RESERVED    = 256;
  localparam int WORD_W          = 32;
  localparam int KB_SHIFT        = 10;

  localparam int CMD_W       = 2;
  localparam int ADDR_W      = 32;
  localparam int SIZE_KB_W   = 23;
  localparam int CNT_OUT_W   = 17;
  localparam int DIV_W       = 33;

  localparam int S_DATA_W    = 40;
  localparam int M_DATA_W    = 72;
  localparam int OUT_BITS    = 67;
  localparam int M_OK_BIT    = 32;
  localparam int M_FREE_LSB  = 33;
  localparam int M_TOTAL_LSB = 50;

  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_MEM_SIZE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_END = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_FREE    = 2'd1,
    CMD_REBUILD = 2'd2
  } cmd_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_REB_TOTAL,
    ST_REB_KEND,
    ST_REB_SWEEP,
    ST_SCAN,
    ST_FREE_DIV,
    ST_FREE_CHK,
    ST_RESP
  } state_t;

  // Index of the lowest clear bit of a map word.
  function automatic logic [4:0] lowest_zero(input logic [WORD_W-1:0] w);
    logic [4:0] idx;
    idx = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!w[i]) begin
        idx = 5'(i);
      end
    end
    return idx;
  endfunction

endpackage

[hw/rtl/bfa_div.sv]
// ----------------------------------------------------------------------------
// bfa_div
// Division by a power-of-two frame size as a registered shift, with done
// raised in the cycle after start.
// ----------------------------------------------------------------------------
module bfa_div import bfa_pkg::*; #(
  parameter int DIVISOR = FRAME_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);

  localparam int SHIFT = $clog2(DIVISOR);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend >> SHIFT;
    end
  end

endmodule

[hw/rtl/bitmap_frame_allocator.sv]
// Alloc: a scan with one map word read per cycle from the bitmap RAM.
// Free: a shift, one map read and the write-back; rebuild: two shifts and a sweep over the map.
// One request is worked at a time; the result register frees the input side at once.
// Reset clears control state and then fills every map word with ones, with s_tready low;
// configuration writes are taken throughout.
// ----------------------------------------------------------------------------
// bitmap_frame_allocator
// Physical frame allocator over a used/free bitmap held in a synchronous RAM.
// ----------------------------------------------------------------------------
module bitmap_frame_allocator import bfa_pkg::*; #(
  parameter int MAX_FRAMES  = MAX_FRAMES_DEF,
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [S_DATA_W-1:0]   s_tdata,    // cmd[1:0], free_addr[33:2]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [M_DATA_W-1:0]   m_tdata,    // frame_addr, ok, free_count, total_count
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int MAP_WORDS = (MAX_FRAMES + WORD_W - 1) / WORD_W;
  localparam int WA_W      = $clog2(MAP_WORDS);
  localparam int WC_W      = $clog2(MAP_WORDS + 1);
  localparam int CNT_W     = $clog2(MAX_FRAMES + 1);
  localparam int FI_W      = WA_W + 5;

  state_t state, state_next;

  logic [SIZE_KB_W-1:0] mem_kb;
  logic [ADDR_W-1:0]    kernel_end_addr;
  logic [CNT_W-1:0]     total, used, resv;
  logic [WC_W-1:0]      ptr;
  logic                 rd_pend;
  logic [WA_W-1:0]      rd_word;
  logic [WA_W-1:0]      fr_word;
  logic [4:0]           fr_bit;
  logic [FI_W-1:0]      res_frame;
  logic                 res_alloc, res_ok;

  logic [ADDR_W-1:0]    out_addr;
  logic                 out_ok;
  logic [CNT_OUT_W-1:0] out_free, out_total;

  logic [WORD_W-1:0] map_mem [MAP_WORDS];
  logic [WORD_W-1:0] map_rdata, map_wdata;
  logic [WA_W-1:0]   map_waddr, map_raddr;
  logic              map_we, map_re;

  logic             div_start, div_done;
  logic [DIV_W-1:0] div_dividend, div_q;

  cmd_t              cmd;
  logic [ADDR_W-1:0] pa;
  logic              accept;
  logic [CNT_W:0]    words_lim;
  logic [CNT_W-1:0]  q_sat, free_now;
  logic              scan_hit, scan_f_ok, scan_last, ptr_last;
  logic [4:0]        scan_j;
  logic [FI_W-1:0]   scan_f;
  logic [WORD_W-1:0] sweep_word;
  logic [ADDR_W-1:0] alloc_addr;

  bfa_div #(.DIVISOR(FRAME_BYTES)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .done     (div_done),
    .quotient (div_q)
  );

  assign cmd      = cmd_t'(s_tdata[CMD_W-1:0]);
  assign pa       = s_tdata[CMD_W+ADDR_W-1:CMD_W];
  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign ptr_last = (ptr == WC_W'(MAP_WORDS - 1));

  assign words_lim = ({1'b0, total} + (CNT_W+1)'(WORD_W - 1)) >> 5;
  assign q_sat     = (div_q > DIV_W'(MAX_FRAMES)) ? CNT_W'(MAX_FRAMES) : div_q[CNT_W-1:0];
  assign free_now  = (total > used) ? (total - used) : '0;

  assign scan_hit  = rd_pend && (map_rdata != '1);
  assign scan_j    = lowest_zero(map_rdata);
  assign scan_f    = {rd_word, scan_j};
  assign scan_f_ok = (DIV_W'(scan_f) < DIV_W'(total));
  assign scan_last = rd_pend && (((CNT_W+1)'(rd_word) + (CNT_W+1)'(1)) == words_lim);

  assign alloc_addr = ADDR_W'(DIV_W'(res_frame) * DIV_W'(FRAME_BYTES));

  // Map word for the rebuild sweep: free only between the reserved low
  // region and the frame total.
  always_comb begin
    logic [CNT_W-1:0] sw_ext, lo_word, tot_word;
    logic             lo_bit, fr_ok;
    sw_ext   = CNT_W'(ptr[WA_W-1:0]);
    lo_word  = resv >> 5;
    tot_word = total >> 5;
    for (int j = 0; j < WORD_W; j++) begin
      lo_bit = (lo_word > sw_ext) || ((lo_word == sw_ext) && (5'(j) < resv[4:0]));
      fr_ok  = (tot_word > sw_ext) || ((tot_word == sw_ext) && (5'(j) < total[4:0]));
      sweep_word[j] = !(fr_ok && !lo_bit);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    map_we       = 1'b0;
    map_waddr    = ptr[WA_W-1:0];
    map_wdata    = '1;
    map_re       = 1'b0;
    map_raddr    = ptr[WA_W-1:0];
    div_start    = 1'b0;
    div_dividend = DIV_W'(mem_kb) << KB_SHIFT;
    case (state)
      ST_INIT: begin
        map_we = 1'b1;
        if (ptr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (cmd)
            CMD_ALLOC: begin
              state_next = (words_lim == '0) ? ST_RESP : ST_SCAN;
            end
            CMD_FREE: begin
              div_start    = 1'b1;
              div_dividend = DIV_W'(pa);
              state_next   = ST_FREE_DIV;
            end
            CMD_REBUILD: begin
              div_start  = 1'b1;
              state_next = ST_REB_TOTAL;
            end
            default: begin
              state_next = ST_RESP;
            end
          endcase
        end
      end
      ST_REB_TOTAL: begin
        if (div_done) begin
          div_start    = 1'b1;
          div_dividend = DIV_W'(kernel_end_addr) + DIV_W'(FRAME_BYTES - 1);
          state_next   = ST_REB_KEND;
        end
      end
      ST_REB_KEND: begin
        if (div_done) begin
          state_next = ST_REB_SWEEP;
        end
      end
      ST_REB_SWEEP: begin
        map_we    = 1'b1;
        map_wdata = sweep_word;
        if (ptr_last) begin
          state_next = ST_RESP;
        end
      end
      ST_SCAN: begin
        if (scan_hit) begin
          if (scan_f_ok) begin
            map_we    = 1'b1;
            map_waddr = rd_word;
            map_wdata = map_rdata | (WORD_W'(1) << scan_j);
          end
          state_next = ST_RESP;
        end else if (scan_last) begin
          state_next = ST_RESP;
        end else if ((CNT_W+1)'(ptr) < words_lim) begin
          map_re = 1'b1;
        end
      end
      ST_FREE_DIV: begin
        if (div_done) begin
          if (div_q < DIV_W'(total)) begin
            map_re     = 1'b1;
            map_raddr  = div_q[WA_W+4:5];
            state_next = ST_FREE_CHK;
          end else begin
            state_next = ST_RESP;
          end
        end
      end
      ST_FREE_CHK: begin
        if (map_rdata[fr_bit]) begin
          map_we    = 1'b1;
          map_waddr = fr_word;
          map_wdata = map_rdata & ~(WORD_W'(1) << fr_bit);
        end
        state_next = ST_RESP;
      end
      ST_RESP: begin
        if (!m_tvalid || m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[map_waddr] <= map_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (map_re) begin
      map_rdata <= map_mem[map_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mem_kb          <= '0;
      kernel_end_addr <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MEM_SIZE:   mem_kb          <= cfg_data[SIZE_KB_W-1:0];
        CFG_KERNEL_END: kernel_end_addr <= cfg_data[ADDR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr       <= '0;
      rd_pend   <= 1'b0;
      total     <= '0;
      used      <= '0;
      res_ok    <= 1'b0;
      res_alloc <= 1'b0;
    end else begin
      case (state)
        ST_INIT: begin
          ptr <= ptr_last ? '0 : ptr + WC_W'(1);
        end
        ST_IDLE: begin
          if (accept) begin
            ptr       <= '0;
            rd_pend   <= 1'b0;
            res_ok    <= 1'b0;
            res_alloc <= 1'b0;
          end
        end
        ST_REB_TOTAL: begin
          if (div_done) begin
            total <= q_sat;
          end
        end
        ST_REB_KEND: begin
          if (div_done) begin
            resv <= (q_sat < CNT_W'(LOW_RESERVED)) ? CNT_W'(LOW_RESERVED) : q_sat;
          end
        end
        ST_REB_SWEEP: begin
          ptr <= ptr_last ? '0 : ptr + WC_W'(1);
          if (ptr_last) begin
            used <= (resv < total) ? resv : total;
          end
        end
        ST_SCAN: begin
          rd_pend <= map_re;
          if (map_re) begin
            rd_word <= ptr[WA_W-1:0];
            ptr     <= ptr + WC_W'(1);
          end
          if (scan_hit && scan_f_ok) begin
            used      <= used + CNT_W'(1);
            res_ok    <= 1'b1;
            res_alloc <= 1'b1;
            res_frame <= scan_f;
          end
        end
        ST_FREE_DIV: begin
          if (div_done) begin
            fr_word <= div_q[WA_W+4:5];
            fr_bit  <= div_q[4:0];
          end
        end
        ST_FREE_CHK: begin
          if (map_rdata[fr_bit]) begin
            res_ok <= 1'b1;
            if (used != '0) begin
              used <= used - CNT_W'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == ST_RESP) && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_RESP) && (!m_tvalid || m_tready)) begin
      out_addr  <= res_alloc ? alloc_addr : '0;
      out_ok    <= res_ok;
      out_free  <= CNT_OUT_W'(free_now);
      out_total <= CNT_OUT_W'(total);
    end
  end

  assign m_tdata = {{(M_DATA_W - OUT_BITS){1'b0}}, out_total, out_free, out_ok, out_addr};

endmodule

[hw/rtl/bfa_checker.sv]
// ----------------------------------------------------------------------------
// bfa_checker
// Port-level checks for the bitmap frame allocator, bound to the top level.
// ----------------------------------------------------------------------------
module bfa_checker import bfa_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [M_DATA_W-1:0]   m_tdata
);

  logic [CNT_OUT_W-1:0] free_cnt, total_cnt;
  logic [ADDR_W-1:0]    frame_addr;
  logic                 ok_flag;

  assign frame_addr = m_tdata[ADDR_W-1:0];
  assign ok_flag    = m_tdata[M_OK_BIT];
  assign free_cnt   = m_tdata[M_FREE_LSB+CNT_OUT_W-1:M_FREE_LSB];
  assign total_cnt  = m_tdata[M_TOTAL_LSB+CNT_OUT_W-1:M_TOTAL_LSB];

  // The map is refilled after reset, so no request is taken right away.
  a_reset_fill: assert property (@(posedge clk) rst |=> !s_tready)
    else $error("request accepted during the map fill after reset");

  // Only one request is in progress at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("request accepted while the previous one is in progress");

  a_free_le_total: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (free_cnt <= total_cnt))
    else $error("free count exceeds total count");

  a_addr_needs_ok: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (frame_addr != '0)) |-> ok_flag)
    else $error("nonzero frame address without ok");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

endmodule

bind bitmap_frame_allocator bfa_checker u_bfa_checker (.*);

[dv/bitmap_frame_allocator_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_frame_allocator_chk
// Watches the request, reply and register ports of the frame allocator. It
// keeps its own copy of the frame bitmap, the used and total frame counters
// and both layout registers. It predicts the reply of every accepted request
// and compares each returned reply with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module bitmap_frame_allocator_chk import bfa_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [S_DATA_W-1:0]   s_tdata,    // cmd[1:0], free_addr[33:2]
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [M_DATA_W-1:0]   m_tdata,    // frame_addr, ok, free_count, total_count
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    replies_seen,
  output int                    grants,
  output int                    refusals
);

  localparam int MAP_WORDS = MAX_FRAMES_DEF / WORD_W;

  typedef struct packed {
    logic [ADDR_W-1:0]    frame_addr;
    logic                 ok;
    logic [CNT_OUT_W-1:0] free_cnt;
    logic [CNT_OUT_W-1:0] total_cnt;
  } frame_reply_t;

  logic [WORD_W-1:0]    frame_bits [MAP_WORDS];
  int unsigned          used_frames_q;
  int unsigned          total_frames_q;
  logic [SIZE_KB_W-1:0] mem_kb_q;
  logic [ADDR_W-1:0]    kernel_end_q;
  frame_reply_t         expected_replies [$];
  int                   err_cnt     = 0;
  int                   reply_cnt   = 0;
  int                   grant_cnt   = 0;
  int                   refusal_cnt = 0;

  assign mismatches   = err_cnt;
  assign replies_seen = reply_cnt;
  assign grants       = grant_cnt;
  assign refusals     = refusal_cnt;

  function automatic logic frame_used(input int f);
    return frame_bits[f / WORD_W][f % WORD_W];
  endfunction

  function automatic void mark_frame(input int f, input logic v);
    frame_bits[f / WORD_W][f % WORD_W] = v;
  endfunction

  function automatic void rebuild_frame_map();
    longint unsigned frames;
    longint unsigned kernel_frames;
    frames = (64'(mem_kb_q) << KB_SHIFT) / FRAME_BYTES_DEF;
    if (frames > MAX_FRAMES_DEF) begin
      frames = MAX_FRAMES_DEF;
    end
    total_frames_q = frames[31:0];
    for (int w = 0; w < MAP_WORDS; w++) begin
      frame_bits[w] = '1;
    end
    for (int f = 0; f < total_frames_q; f++) begin
      mark_frame(f, 1'b0);
    end
    for (int f = 0; f < LOW_RESERVED; f++) begin
      mark_frame(f, 1'b1);
    end
    kernel_frames = (64'(kernel_end_q) + FRAME_BYTES_DEF - 1) / FRAME_BYTES_DEF;
    if (kernel_frames > MAX_FRAMES_DEF) begin
      kernel_frames = MAX_FRAMES_DEF;
    end
    for (int f = LOW_RESERVED; f < kernel_frames; f++) begin
      mark_frame(f, 1'b1);
    end
    used_frames_q = 0;
    for (int f = 0; f < total_frames_q; f++) begin
      if (frame_used(f)) begin
        used_frames_q++;
      end
    end
  endfunction

  function automatic frame_reply_t allocator_step(input logic [CMD_W-1:0] op,
                                                  input logic [ADDR_W-1:0] pa);
    frame_reply_t r;
    int           f;
    bit           found;
    r     = '0;
    f     = 0;
    found = 1'b0;
    case (op)
      CMD_ALLOC: begin
        for (int w = 0; w * WORD_W < total_frames_q && !found; w++) begin
          if (frame_bits[w] != '1) begin
            for (int j = 0; j < WORD_W && !found; j++) begin
              f = w * WORD_W + j;
              if (f < total_frames_q && !frame_used(f)) begin
                found = 1'b1;
              end
            end
          end
        end
        if (found) begin
          mark_frame(f, 1'b1);
          used_frames_q++;
          r.frame_addr = ADDR_W'(64'(f) * FRAME_BYTES_DEF);
          r.ok         = 1'b1;
        end
      end
      CMD_FREE: begin
        f = int'(pa / FRAME_BYTES_DEF);
        if (f < total_frames_q && frame_used(f)) begin
          mark_frame(f, 1'b0);
          if (used_frames_q > 0) begin
            used_frames_q--;
          end
          r.ok = 1'b1;
        end
      end
      CMD_REBUILD: begin
        rebuild_frame_map();
      end
      default: begin
      end
    endcase
    r.free_cnt  = (total_frames_q > used_frames_q) ?
                  CNT_OUT_W'(total_frames_q - used_frames_q) : '0;
    r.total_cnt = CNT_OUT_W'(total_frames_q);
    return r;
  endfunction

  always @(posedge clk) begin : reply_watch
    frame_reply_t want;
    frame_reply_t got;
    if (rst) begin
      for (int w = 0; w < MAP_WORDS; w++) begin
        frame_bits[w] = '1;
      end
      used_frames_q  = 0;
      total_frames_q = 0;
      mem_kb_q       = '0;
      kernel_end_q   = '0;
      expected_replies.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_MEM_SIZE) begin
          mem_kb_q = cfg_data[SIZE_KB_W-1:0];
        end else if (cfg_index == CFG_KERNEL_END) begin
          kernel_end_q = cfg_data[ADDR_W-1:0];
        end
      end
      // A reply accepted at this edge cannot belong to a request taken at it.
      if (m_tvalid && m_tready) begin
        got.frame_addr = m_tdata[ADDR_W-1:0];
        got.ok         = m_tdata[M_OK_BIT];
        got.free_cnt   = m_tdata[M_FREE_LSB +: CNT_OUT_W];
        got.total_cnt  = m_tdata[M_TOTAL_LSB +: CNT_OUT_W];
        reply_cnt++;
        if (expected_replies.size() == 0) begin
          err_cnt++;
          $display("%0t: reply with none expected, expected nothing, got %h", $time,
                   got);
        end else begin
          want = expected_replies.pop_front();
          if (got.frame_addr !== want.frame_addr) begin
            err_cnt++;
            $display("%0t: frame_addr expected %h, got %h", $time, want.frame_addr,
                     got.frame_addr);
          end
          if (got.ok !== want.ok) begin
            err_cnt++;
            $display("%0t: ok expected %b, got %b", $time, want.ok, got.ok);
          end
          if (got.free_cnt !== want.free_cnt) begin
            err_cnt++;
            $display("%0t: free_count expected %0d, got %0d", $time, want.free_cnt,
                     got.free_cnt);
          end
          if (got.total_cnt !== want.total_cnt) begin
            err_cnt++;
            $display("%0t: total_count expected %0d, got %0d", $time, want.total_cnt,
                     got.total_cnt);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        want = allocator_step(s_tdata[CMD_W-1:0], s_tdata[CMD_W +: ADDR_W]);
        if (s_tdata[CMD_W-1:0] == CMD_ALLOC) begin
          if (want.ok) begin
            grant_cnt++;
          end else begin
            refusal_cnt++;
          end
        end
        expected_replies.push_back(want);
      end
    end
  end

endmodule

[dv/bitmap_frame_allocator_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_frame_allocator_tb
// Drives allocate, free, rebuild and unused-code requests into the frame allocator under a
// series of memory layouts. A directed opening covers the empty map, reserved
// and kernel frames, double frees, frees past the total, a partial last map
// word, exhaustion and saturated sizes; random requests follow. The checker
// beside the block predicts and compares every reply.
// ----------------------------------------------------------------------------
module bitmap_frame_allocator_tb;
  import bfa_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int RESET_CYCLES = 9;
  localparam int LAYOUTS      = 11;
  localparam int HOLD_LAYOUT  = 3;
  localparam int HOLD_CYCLES  = 3000;
  localparam int STALL_LIMIT  = 20000;
  localparam int TAIL_CYCLES  = 64;
  localparam int MEM_KB_HIGH  = 4194304;

  logic                  clk;
  logic                  rst       = 1'b1;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [S_DATA_W-1:0]   s_tdata   = '0;   // cmd[1:0], free_addr[33:2]
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [M_DATA_W-1:0]   m_tdata;          // frame_addr, ok, free_count, total_count
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  int          mismatches;
  int          replies_seen;
  int          grants;
  int          refusals;
  int          requests_sent = 0;
  int          burst_left    = 0;
  int          stall_cycles  = 0;
  int unsigned frame_total   = 0;
  bit          hold_pending  = 1'b0;

  bitmap_frame_allocator u_dut (.*);

  bitmap_frame_allocator_chk u_chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic send(input logic [CMD_W-1:0] op, input logic [ADDR_W-1:0] pa);
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) == 0) begin
        burst_left = $urandom_range(20, 60);
        gap        = 0;
      end else begin
        burst_left = $urandom_range(1, 8);
        gap        = $urandom_range(1, 6);
      end
      if (gap > 0 && s_tvalid) begin
        s_tvalid <= 1'b0;
      end
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(S_DATA_W - CMD_W - ADDR_W){1'b0}}, pa, op};
    burst_left--;
    do @(posedge clk); while (s_tready !== 1'b1);
    requests_sent++;
  endtask

  task automatic drain();
    if (s_tvalid) begin
      s_tvalid <= 1'b0;
    end
    burst_left = 0;
    while (replies_seen < requests_sent) @(posedge clk);
  endtask

  task automatic load_layout(input logic [SIZE_KB_W-1:0] kb, input logic [ADDR_W-1:0] kend);
    longint unsigned frames;
    frames      = (64'(kb) << KB_SHIFT) / FRAME_BYTES_DEF;
    frame_total = (frames > MAX_FRAMES_DEF) ? MAX_FRAMES_DEF : frames[31:0];
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MEM_SIZE;
    cfg_data  <= CFG_DATA_W'(kb);
    @(posedge clk);
    cfg_index <= CFG_KERNEL_END;
    cfg_data  <= kend;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [ADDR_W-1:0] pick_free_addr();
    int unsigned roll;
    int unsigned frame;
    roll = $urandom_range(0, 99);
    if (frame_total == 0 || roll < 15) begin
      return $urandom();
    end
    if (roll < 30) begin
      frame = frame_total - 1 + $urandom_range(0, 2);
    end else begin
      frame = $urandom_range(0, frame_total - 1);
    end
    return ADDR_W'(64'(frame) * FRAME_BYTES_DEF + $urandom_range(0, FRAME_BYTES_DEF - 1));
  endfunction

  initial begin : reply_pacing
    int pct;
    int left_in_mode;
    int hold_left;
    pct          = 100;
    left_in_mode = 0;
    hold_left    = 0;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && hold_pending) begin
        hold_pending = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        if (left_in_mode == 0) begin
          left_in_mode = $urandom_range(20, 120);
          case ($urandom_range(0, 3))
            0: pct = 100;
            1: pct = 75;
            2: pct = 40;
            default: pct = 90;
          endcase
        end
        left_in_mode--;
        m_tready <= ($urandom_range(0, 99) < pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("bitmap_frame_allocator regression: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [SIZE_KB_W-1:0] kb;
    logic [ADDR_W-1:0]    kend;
    int                   items;
    int                   alloc_pct;
    int                   roll;
    int                   sel;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // The map starts fully reserved with a total of zero.
    send(CMD_ALLOC, 32'h0);
    send(CMD_FREE, 32'h0);
    send(CMD_UNUSED, 32'hFFFF_FFFF);
    send(CMD_REBUILD, 32'h0);

    // 300 frames with the kernel image reaching one frame past the low block.
    drain();
    load_layout(23'd1200, 32'h0010_0001);
    send(CMD_REBUILD, 32'h0);
    send(CMD_ALLOC, 32'h0);
    send(CMD_ALLOC, 32'h0);
    send(CMD_FREE, 32'h0010_1000);
    send(CMD_FREE, 32'h0010_1FFF);
    send(CMD_FREE, 32'hFFFF_FFFF);
    send(CMD_FREE, 32'h0012_C000);
    send(CMD_FREE, 32'h0);
    send(CMD_ALLOC, 32'h0);
    send(CMD_UNUSED, 32'h5555_AAAA);

    // 260 frames leave four free frames in a partial last word.
    drain();
    load_layout(23'd1040, 32'h0);
    send(CMD_REBUILD, 32'h0);
    repeat (5) send(CMD_ALLOC, 32'hFFFF_FFFF);

    drain();
    load_layout('1, 32'hFFFF_FFFF);
    send(CMD_REBUILD, 32'h0);
    send(CMD_ALLOC, 32'h0);
    send(CMD_FREE, 32'h0FFF_F000);
    send(CMD_ALLOC, 32'h0);

    for (int p = 0; p < LAYOUTS; p++) begin
      drain();
      sel = (p < 3) ? p : $urandom_range(0, 9);
      case (sel)
        0: begin
          kb   = '1;
          kend = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 32'h0020_0000);
        end
        1: begin
          kb   = SIZE_KB_W'(MEM_KB_HIGH);
          kend = $urandom_range(0, 32'h0020_0000);
        end
        2: begin
          kb   = SIZE_KB_W'($urandom_range(0, 1023));
          kend = $urandom();
        end
        default: begin
          kb   = SIZE_KB_W'($urandom_range(1028, 4096));
          kend = $urandom_range(0, (int'(kb) / 4 + 8) * FRAME_BYTES_DEF);
        end
      endcase
      load_layout(kb, kend);
      if (p == HOLD_LAYOUT) begin
        hold_pending = 1'b1;
      end
      send(CMD_REBUILD, $urandom());
      items     = $urandom_range(20, 26);
      alloc_pct = $urandom_range(30, 70);
      repeat (items) begin
        roll = $urandom_range(0, 99);
        if (roll < alloc_pct) begin
          send(CMD_ALLOC, $urandom());
        end else if (roll < 90) begin
          send(CMD_FREE, pick_free_addr());
        end else if (roll < 95) begin
          send(CMD_REBUILD, $urandom());
        end else begin
          send(CMD_UNUSED, $urandom());
        end
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Covered %0d requests over %0d memory layouts: %0d frames granted, %0d refused.",
             requests_sent, LAYOUTS + 4, grants, refusals);
    $display("Included empty and saturated sizes, kernel images past the map and a %0d-cycle hold.",
             HOLD_CYCLES);
    if (mismatches == 0 && replies_seen == requests_sent) begin
      $display("bitmap_frame_allocator regression: pass");
    end else begin
      $display("bitmap_frame_allocator regression: fail");
    end
    $finish;
  end

endmodule
